// ===== hdl/knps_pkg.sv =====
// ----------------------------------------------------------------------------
// knps_pkg
// Types and constants shared by the nearest-point selector modules.
// ----------------------------------------------------------------------------
package knps_pkg;

    localparam int ID_W   = 16;
    localparam int POS_W  = 20;
    localparam int DIFF_W = 21;
    localparam int SQ_W   = 41;
    localparam int DIST_W = 44;
    localparam int AGE_W  = 32;
    localparam int MC_W   = 5;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [MC_W-1:0] MAX_COUNT_RST = 5'd4;

    typedef enum logic [1:0] {
        REG_MAX_COUNT,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_DECIDE,
        S_SCAN,
        S_WRITE,
        S_CHECK,
        S_ESCAN,
        S_EOUT,
        S_ROUT,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic load;
        logic sq_step;
        logic decide;
        logic scan_init;
        logic scan_step;
        logic scan_write;
        logic sel_out;
        logic raw_out;
        logic clear_query;
    } cmd_t;

    typedef struct packed {
        logic sq_last;
        logic raw_put;
        logic item_ok;
        logic scan_last;
        logic is_last;
        logic kk_zero;
        logic raw_mode;
        logic any_valid;
        logic one_left;
        logic raw_last;
    } status_t;

endpackage

// ===== hdl/knps_ctrl.sv =====
// ----------------------------------------------------------------------------
// knps_ctrl
// Sequencer: distance, slot scan, replacement and result emission.
// ----------------------------------------------------------------------------
module knps_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  knps_pkg::status_t status,
    output knps_pkg::cmd_t   cmd,
    output logic             busy
);
    import knps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (status.sq_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.raw_put && status.item_ok)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!status.is_last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.kk_zero)
                begin
                    state_next = S_CLEAR;
                end
                else if (status.raw_mode)
                begin
                    state_next = S_ROUT;
                end
                else if (status.any_valid)
                begin
                    state_next = S_ESCAN;
                end
                else
                begin
                    state_next = S_CLEAR;
                end
            end
            S_ESCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_EOUT;
                end
            end
            S_EOUT:
            begin
                if (status.one_left)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_ESCAN;
                end
            end
            S_ROUT:
            begin
                if (status.raw_last)
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.load        = start;
            S_SQ:     cmd.sq_step     = 1'b1;
            S_DECIDE:
            begin
                cmd.decide    = 1'b1;
                cmd.scan_init = 1'b1;
            end
            S_SCAN:   cmd.scan_step   = 1'b1;
            S_WRITE:  cmd.scan_write  = 1'b1;
            S_CHECK:  cmd.scan_init   = 1'b1;
            S_ESCAN:  cmd.scan_step   = 1'b1;
            S_EOUT:
            begin
                cmd.sel_out   = 1'b1;
                cmd.scan_init = 1'b1;
            end
            S_ROUT:   cmd.raw_out     = 1'b1;
            S_CLEAR:  cmd.clear_query = 1'b1;
            default:  cmd = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_start_goes_sq: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_SQ))
        else $error("accepted word did not enter the distance step");

    a_scan_ends_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && status.scan_last) |=> (state_reg == S_WRITE))
        else $error("slot scan did not end in a write decision");

    a_clear_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> (state_reg == S_IDLE))
        else $error("query clear did not return to idle");

endmodule

// ===== hdl/knps_dp.sv =====
// ----------------------------------------------------------------------------
// knps_dp
// Datapath: squared distance, slot store, farthest-slot search and outputs.
// ----------------------------------------------------------------------------
module knps_dp
#(
    parameter int K_MAX = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  knps_pkg::cmd_t                       cmd,
    output knps_pkg::status_t                    status,
    input  logic [knps_pkg::ID_W-1:0]            target_id,
    input  logic signed [knps_pkg::POS_W-1:0]    pos_x,
    input  logic signed [knps_pkg::POS_W-1:0]    pos_y,
    input  logic signed [knps_pkg::POS_W-1:0]    pos_z,
    input  logic                                 is_valid,
    input  logic                                 last_in,
    input  logic [knps_pkg::MC_W-1:0]            max_count,
    input  logic signed [knps_pkg::POS_W-1:0]    origin_x,
    input  logic signed [knps_pkg::POS_W-1:0]    origin_y,
    input  logic signed [knps_pkg::POS_W-1:0]    origin_z,
    output logic                                 result_strobe,
    output logic [knps_pkg::ID_W-1:0]            chosen_id,
    output logic                                 last_out
);
    import knps_pkg::*;

    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CW = $clog2(K_MAX + 1);

    // item word
    logic [ID_W-1:0]         id_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic                    ok_reg;
    logic                    last_reg;
    logic [AGE_W-1:0]        age_reg;

    // distance
    logic [1:0]                sq_cnt_reg;
    logic signed [POS_W-1:0]   sel_p, sel_o;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic [SQ_W-1:0]           prod_reg;
    logic [DIST_W-1:0]         acc_reg;

    // slot store
    logic [ID_W-1:0]   slot_id_mem   [K_MAX];
    logic [DIST_W-1:0] slot_dist_mem [K_MAX];
    logic [AGE_W-1:0]  slot_age_mem  [K_MAX];
    logic [K_MAX-1:0]  valid_reg, valid_next;
    logic [K_MAX-1:0]  itok_reg, itok_next;
    logic              raw_mode_reg;
    logic [AGE_W-1:0]  items_seen_reg;

    // scan
    logic [IW-1:0]     idx_reg;
    logic [CW-1:0]     used_reg;
    logic              free_found_reg;
    logic [IW-1:0]     free_idx_reg;
    logic              far_found_reg;
    logic [IW-1:0]     far_idx_reg;
    logic [DIST_W-1:0] far_dist_reg;
    logic [AGE_W-1:0]  far_age_reg;
    logic [ID_W-1:0]   far_id_reg;

    logic [ID_W-1:0]   rd_id;
    logic [DIST_W-1:0] rd_dist;
    logic [AGE_W-1:0]  rd_age;
    logic              rd_valid;
    logic              is_farther;

    logic [CW-1:0]     kk;
    logic [CW-1:0]     vcount;
    logic              raw_wr, sc_free, sc_far, wr_en, wr_ok;
    logic [IW-1:0]     wr_idx;

    logic              strobe_reg;
    logic [ID_W-1:0]   chosen_reg;
    logic              last_out_reg;

    assign kk = ({{(32-MC_W){1'b0}}, max_count} > 32'(K_MAX)) ? CW'(K_MAX) : CW'(max_count);

    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:
            begin
                sel_p = px_reg;
                sel_o = origin_x;
            end
            2'd1:
            begin
                sel_p = py_reg;
                sel_o = origin_y;
            end
            default:
            begin
                sel_p = pz_reg;
                sel_o = origin_z;
            end
        endcase
    end

    assign diff    = {sel_p[POS_W-1], sel_p} - {sel_o[POS_W-1], sel_o};
    assign sq_full = diff * diff;

    assign rd_id    = slot_id_mem[idx_reg];
    assign rd_dist  = slot_dist_mem[idx_reg];
    assign rd_age   = slot_age_mem[idx_reg];
    assign rd_valid = valid_reg[idx_reg];

    // later arrival counts as farther on equal distance
    assign is_farther = (rd_dist > far_dist_reg) ||
                        ((rd_dist == far_dist_reg) && (rd_age > far_age_reg));

    always_comb
    begin
        vcount = '0;
        for (int i = 0; i < K_MAX; i++)
        begin
            vcount = vcount + CW'(valid_reg[i]);
        end
    end

    assign status.sq_last   = (sq_cnt_reg == 2'd3);
    assign status.raw_put   = raw_mode_reg && (items_seen_reg < AGE_W'(kk));
    assign status.item_ok   = ok_reg;
    assign status.scan_last = (idx_reg == IW'(K_MAX - 1));
    assign status.is_last   = last_reg;
    assign status.kk_zero   = (kk == '0);
    assign status.raw_mode  = raw_mode_reg;
    assign status.any_valid = |valid_reg;
    assign status.one_left  = (vcount == CW'(1));
    assign status.raw_last  = (AGE_W'(idx_reg) == (items_seen_reg - AGE_W'(1)));

    assign raw_wr  = cmd.decide && status.raw_put;
    assign sc_free = (used_reg < kk) && free_found_reg;
    assign sc_far  = far_found_reg && (acc_reg < far_dist_reg);
    assign wr_en   = raw_wr || (cmd.scan_write && (sc_free || sc_far));
    assign wr_ok   = raw_wr ? ok_reg : 1'b1;
    assign wr_idx  = raw_wr ? items_seen_reg[IW-1:0] : (sc_free ? free_idx_reg : far_idx_reg);

    always_comb
    begin
        valid_next = valid_reg;
        itok_next  = itok_reg;
        if (cmd.clear_query)
        begin
            valid_next = '0;
            itok_next  = '0;
        end
        else
        begin
            // leaving arrival order: drop stored invalid words
            if (cmd.decide && !status.raw_put && raw_mode_reg)
            begin
                valid_next = valid_reg & itok_reg;
            end
            if (wr_en)
            begin
                valid_next[wr_idx] = 1'b1;
                itok_next[wr_idx]  = wr_ok;
            end
            if (cmd.sel_out)
            begin
                valid_next[far_idx_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            itok_reg       <= '0;
            raw_mode_reg   <= 1'b1;
            items_seen_reg <= '0;
            ok_reg         <= 1'b0;
            last_reg       <= 1'b0;
            sq_cnt_reg     <= '0;
            idx_reg        <= '0;
            used_reg       <= '0;
            free_found_reg <= 1'b0;
            far_found_reg  <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            itok_reg   <= itok_next;
            strobe_reg <= cmd.sel_out || cmd.raw_out;
            if (cmd.load)
            begin
                ok_reg     <= is_valid;
                last_reg   <= last_in;
                sq_cnt_reg <= '0;
            end
            if (cmd.sq_step)
            begin
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
            end
            if (cmd.clear_query)
            begin
                raw_mode_reg   <= 1'b1;
                items_seen_reg <= '0;
            end
            else if (cmd.decide)
            begin
                items_seen_reg <= items_seen_reg + AGE_W'(1);
                if (!status.raw_put)
                begin
                    raw_mode_reg <= 1'b0;
                end
            end
            if (cmd.scan_init)
            begin
                idx_reg        <= '0;
                used_reg       <= '0;
                free_found_reg <= 1'b0;
                far_found_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (rd_valid)
                begin
                    used_reg <= used_reg + CW'(1);
                    if (!far_found_reg || is_farther)
                    begin
                        far_found_reg <= 1'b1;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            else if (cmd.raw_out)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg  <= target_id;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            age_reg <= items_seen_reg;
            acc_reg <= '0;
        end
        else if (cmd.sq_step && (sq_cnt_reg != 2'd0))
        begin
            acc_reg <= acc_reg + DIST_W'(prod_reg);
        end
        if (cmd.sq_step)
        begin
            prod_reg <= sq_full[SQ_W-1:0];
        end
        if (cmd.scan_step)
        begin
            if (rd_valid)
            begin
                if (!far_found_reg || is_farther)
                begin
                    far_idx_reg  <= idx_reg;
                    far_dist_reg <= rd_dist;
                    far_age_reg  <= rd_age;
                    far_id_reg   <= rd_id;
                end
            end
            else if (!free_found_reg)
            begin
                free_idx_reg <= idx_reg;
            end
        end
        if (cmd.sel_out)
        begin
            chosen_reg   <= far_id_reg;
            last_out_reg <= status.one_left;
        end
        else if (cmd.raw_out)
        begin
            chosen_reg   <= rd_id;
            last_out_reg <= status.raw_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_id_mem[wr_idx]   <= id_reg;
            slot_dist_mem[wr_idx] <= acc_reg;
            slot_age_mem[wr_idx]  <= age_reg;
        end
    end

    assign result_strobe = strobe_reg;
    assign chosen_id     = chosen_reg;
    assign last_out      = last_out_reg;

    a_raw_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        raw_mode_reg |-> (AGE_W'(vcount) == items_seen_reg))
        else $error("arrival-order slots out of step with word count");

    a_clear_restores: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_query |=> (raw_mode_reg && (items_seen_reg == '0) && (valid_reg == '0)))
        else $error("query clear left state behind");

    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_out) |=> !result_strobe)
        else $error("result word after final result");

endmodule

// ===== hdl/k_nearest_point_selector.sv =====
// ----------------------------------------------------------------------------
// k_nearest_point_selector
// Keeps the nearest valid targets to a programmable origin; APB config.
// ----------------------------------------------------------------------------
// A non-final word keeps busy high through distance, decide and check, and
//   also through a full slot scan when a valid word seeks a replacement.
// A new word is taken only once busy falls, paced by the single squarer and
//   the one-slot-per-cycle scan. Final word: arrival-order results one per
//   cycle (every word, invalid too); selected results after a full scan each.
// Results are one-cycle strobes; the receiver cannot stall. Async active-low
//   reset clears control state and loads max_count 4, origin 0.
module k_nearest_point_selector
#(
    parameter int K_MAX = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [knps_pkg::ID_W-1:0]            target_id,
    input  logic signed [knps_pkg::POS_W-1:0]    pos_x,
    input  logic signed [knps_pkg::POS_W-1:0]    pos_y,
    input  logic signed [knps_pkg::POS_W-1:0]    pos_z,
    input  logic                                 is_valid,
    input  logic                                 last_in,
    output logic                                 result_strobe,
    output logic [knps_pkg::ID_W-1:0]            chosen_id,
    output logic                                 last_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [knps_pkg::ADDR_W-1:0]          paddr,
    input  logic [knps_pkg::DATA_W-1:0]          pwdata,
    output logic [knps_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import knps_pkg::*;

    logic [MC_W-1:0]         max_count_reg;
    logic signed [POS_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic                    wr_stb;
    reg_idx_t                reg_sel;
    cmd_t                    cmd;
    status_t                 status;

    assign pready  = 1'b1;
    assign wr_stb  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= MAX_COUNT_RST;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
        end
        else if (wr_stb)
        begin
            unique case (reg_sel)
                REG_MAX_COUNT: max_count_reg <= pwdata[MC_W-1:0];
                REG_ORIGIN_X:  origin_x_reg  <= pwdata[POS_W-1:0];
                REG_ORIGIN_Y:  origin_y_reg  <= pwdata[POS_W-1:0];
                REG_ORIGIN_Z:  origin_z_reg  <= pwdata[POS_W-1:0];
                default:       max_count_reg <= max_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_COUNT: prdata = {{(DATA_W-MC_W){1'b0}}, max_count_reg};
            REG_ORIGIN_X:  prdata = {{(DATA_W-POS_W){origin_x_reg[POS_W-1]}}, origin_x_reg};
            REG_ORIGIN_Y:  prdata = {{(DATA_W-POS_W){origin_y_reg[POS_W-1]}}, origin_y_reg};
            REG_ORIGIN_Z:  prdata = {{(DATA_W-POS_W){origin_z_reg[POS_W-1]}}, origin_z_reg};
            default:       prdata = '0;
        endcase
    end

    knps_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    knps_dp #(.K_MAX(K_MAX)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .target_id     (target_id),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .is_valid      (is_valid),
        .last_in       (last_in),
        .max_count     (max_count_reg),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .origin_z      (origin_z_reg),
        .result_strobe (result_strobe),
        .chosen_id     (chosen_id),
        .last_out      (last_out)
    );

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result word while idle");

endmodule
